FILE: sv/n7s_pkg.sv
// ----------------------------------------------------------------------------
// n7s_pkg
// Shared types, constants and segment tables for the seven-segment coder.
// ----------------------------------------------------------------------------
`default_nettype none
package n7s_pkg;

  localparam int unsigned NumDigits = 8;
  localparam int unsigned SegW      = 8;
  // working value: mant (24b) * 10^7 (24b) = 48b max
  localparam int unsigned AccW      = 48;

  localparam logic [SegW-1:0] SegBlank = 8'h00;
  localparam logic [SegW-1:0] SegZero  = 8'h3f;
  localparam logic [SegW-1:0] SegE     = 8'h79;
  localparam logic [SegW-1:0] SegMinus = 8'h40;
  localparam logic [SegW-1:0] SegPoint = 8'h80;

  typedef logic [SegW-1:0] seg_t;

  // datapath commands from the controller
  typedef struct packed {
    logic load;      // decode the operand
    logic scale;     // form n = mant*10^(8-p) >> shift
    logic digit;     // peel one decimal digit
    logic finish;    // forced zeros, point, overflow pattern
    logic shift;     // one step of trailing-zero shift
    logic minus;     // place minus
  } n7s_cmd_t;

  typedef struct packed {
    logic trail_zero; // rightmost code is a plain zero
  } n7s_sts_t;

  function automatic seg_t digit_code(input logic [3:0] d);
    seg_t s;
    case (d)
      4'd0: s = 8'h3f;
      4'd1: s = 8'h06;
      4'd2: s = 8'h5b;
      4'd3: s = 8'h4f;
      4'd4: s = 8'h66;
      4'd5: s = 8'h6d;
      4'd6: s = 8'h7d;
      4'd7: s = 8'h07;
      4'd8: s = 8'h7f;
      4'd9: s = 8'h6f;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [23:0] pow10(input logic [3:0] k);
    logic [23:0] v;
    case (k)
      4'd0: v = 24'd1;
      4'd1: v = 24'd10;
      4'd2: v = 24'd100;
      4'd3: v = 24'd1000;
      4'd4: v = 24'd10000;
      4'd5: v = 24'd100000;
      4'd6: v = 24'd1000000;
      4'd7: v = 24'd10000000;
      default: v = 24'd1;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: sv/number_to_seven_segment.sv
// Sequence from input transaction to result valid: scale, eight digit
// steps, finish, 0 to 7 shift steps plus one check, then minus.
// Flow: one item at a time; the input is ready again in the cycle after
// the result leaves.
// The digit steps and the trailing-zero shift loop are the long parts of the sequence.
// Reset: synchronous active-high rst returns the sequencer to idle.
// ----------------------------------------------------------------------------
// number_to_seven_segment
// Float bit pattern in, eight seven-segment codes and overflow flag out.
// ----------------------------------------------------------------------------
`default_nettype none
module number_to_seven_segment (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // value_bits
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata   // seg0..seg7 [63:0], overflow [64], zeros
);
  import n7s_pkg::*;

  n7s_cmd_t    cmd;
  n7s_sts_t    sts;
  logic        idle, done;
  logic [63:0] segs;
  logic        ovf;

  n7s_ctrl u_ctrl (
    .clk, .rst,
    .in_fire(s_tvalid && s_tready),
    .out_fire(m_tvalid && m_tready),
    .sts, .cmd, .idle, .done
  );

  n7s_datapath u_dp (
    .clk, .value_bits(s_tdata), .cmd, .sts, .segs, .overflow(ovf)
  );

  assign s_tready = idle;
  assign m_tvalid = done;
  assign m_tdata  = {7'd0, ovf, segs};
endmodule
`default_nettype wire

FILE: sv/n7s_datapath.sv
// ----------------------------------------------------------------------------
// n7s_datapath
// Operand decode, scaling, digit extraction and display shaping.
// ----------------------------------------------------------------------------
`default_nettype none
module n7s_datapath (
  input  wire logic              clk,
  input  wire logic [31:0]       value_bits,
  input  wire n7s_pkg::n7s_cmd_t cmd,
  output n7s_pkg::n7s_sts_t      sts,
  output logic [63:0]            segs,
  output logic                   overflow
);
  import n7s_pkg::*;

  logic              neg;
  logic [23:0]       mant;
  logic [7:0]        rsh;      // right shift amount, 0..149
  logic [1:0]        lsh;      // left shift amount, 0..3
  logic              ovf;
  logic              int_ge1;
  logic [3:0]        p;        // integer digit count 1..8
  logic [AccW-1:0]   n;
  logic [26:0]       ipart_w;
  seg_t              seg [NumDigits];
  logic [2:0]        dcnt;

  // decode
  logic [7:0]  ef;
  logic [22:0] frac;
  logic [23:0] m_w;
  logic [7:0]  rsh_w;
  logic [1:0]  lsh_w;
  logic        big_w;
  logic [3:0]  p_w;
  always_comb begin
    ef    = value_bits[30:23];
    frac  = value_bits[22:0];
    m_w   = (ef == 8'd0) ? {1'b0, frac} : {1'b1, frac};
    big_w = (ef == 8'hff) || (ef >= 8'd154);
    // exp2 = ef-150 (or -149): rsh = -exp2 when negative
    lsh_w = 2'd0;
    rsh_w = 8'd0;
    if (ef == 8'd0) rsh_w = 8'd149;
    else if (ef < 8'd150) rsh_w = 8'd150 - ef;
    else lsh_w = 2'(ef - 8'd150);
    if (rsh_w >= 8'd27) ipart_w = '0;
    else ipart_w = ({3'b0, m_w} << lsh_w) >> rsh_w[4:0];
    p_w = 4'd1;
    for (int k = 1; k < 8; k++)
      if (ipart_w >= 27'(pow10(4'(k)))) p_w = 4'(k + 1);
  end

  logic [AccW-1:0] prod;
  logic [AccW-1:0] scaled;
  assign prod = AccW'(mant) * AccW'(pow10(4'd8 - p));
  always_comb begin
    if (rsh >= 8'(AccW)) scaled = '0;
    else scaled = (prod << lsh) >> rsh[5:0];
  end

  // divide by ten via reciprocal: n < 1e8, q = (n * ceil(2^31/10)) >> 31
  logic [26:0] nq;
  logic [3:0]  nr;
  logic [57:0] qm;
  assign qm = {31'd0, n[26:0]} * 58'd214748365;
  always_comb begin
    nq = qm[57:31];
    nr = 4'(n[26:0] - nq * 27'd10);
  end

  // finish pattern: forced zeros, then the decimal point
  seg_t fin_seg [NumDigits];
  always_comb begin
    for (int i = 0; i < 8; i++) fin_seg[i] = seg[i];
    if (int_ge1) fin_seg[6] = SegZero;
    fin_seg[7] = SegZero;
    fin_seg[3'(p - 4'd1)] = fin_seg[3'(p - 4'd1)] | SegPoint;
  end

  // rightmost blank among positions 6..0
  logic [2:0] pos;
  logic       pos_ok;
  always_comb begin
    pos = 3'd0;
    pos_ok = 1'b0;
    for (int i = 0; i < 7; i++)
      if (seg[i] == SegBlank) begin
        pos = 3'(i);
        pos_ok = 1'b1;
      end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ovf     <= big_w || (ipart_w >= 27'd100000000);
      mant    <= m_w;
      rsh     <= rsh_w;
      lsh     <= lsh_w;
      int_ge1 <= (ipart_w != '0);
      p       <= p_w;
      neg     <= value_bits[31] && !(ef == 8'hff && frac != '0)
                 && !(ef == 8'd0 && frac == '0);
      dcnt    <= 3'd7;
    end
    if (cmd.scale) n <= scaled;
    if (cmd.digit) begin
      seg[dcnt] <= digit_code(nr);
      n         <= AccW'(nq);
      dcnt      <= dcnt - 3'd1;
    end
    if (cmd.finish) begin
      if (ovf) begin
        for (int i = 0; i < 7; i++) seg[i] <= SegBlank;
        seg[7] <= SegE;
      end else begin
        for (int i = 0; i < 8; i++) seg[i] <= fin_seg[i];
      end
    end
    if (cmd.shift) begin
      for (int i = 7; i > 0; i--) seg[i] <= seg[i-1];
      seg[0] <= SegBlank;
    end
    if (cmd.minus && neg) begin
      if (pos_ok) seg[pos] <= SegMinus;
    end
  end

  assign sts.trail_zero = (seg[7] == SegZero);
  assign overflow = ovf;
  always_comb
    for (int i = 0; i < 8; i++) segs[i*8 +: 8] = seg[i];
endmodule
`default_nettype wire

FILE: sv/n7s_ctrl.sv
// ----------------------------------------------------------------------------
// n7s_ctrl
// Sequencer: load, scale, eight digit steps, finish, shift loop, minus.
// ----------------------------------------------------------------------------
`default_nettype none
module n7s_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_fire,
  input  wire logic              out_fire,
  input  wire n7s_pkg::n7s_sts_t sts,
  output n7s_pkg::n7s_cmd_t      cmd,
  output logic                   idle,
  output logic                   done
);
  import n7s_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCALE, ST_DIGIT, ST_FINISH, ST_SHIFT, ST_MINUS, ST_DONE
  } state_t;

  state_t     state;
  logic [2:0] cnt;

  always_comb begin
    cmd = '0;
    cmd.load   = (state == ST_IDLE) && in_fire;
    cmd.scale  = (state == ST_SCALE);
    cmd.digit  = (state == ST_DIGIT);
    cmd.finish = (state == ST_FINISH);
    cmd.shift  = (state == ST_SHIFT) && sts.trail_zero;
    cmd.minus  = (state == ST_MINUS);
  end
  assign idle = (state == ST_IDLE);
  assign done = (state == ST_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE:   if (in_fire) state <= ST_SCALE;
        ST_SCALE:  begin state <= ST_DIGIT; cnt <= 3'd7; end
        ST_DIGIT:  begin
          if (cnt == 3'd0) state <= ST_FINISH;
          cnt <= cnt - 3'd1;
        end
        ST_FINISH: state <= ST_SHIFT;
        ST_SHIFT:  if (!sts.trail_zero) state <= ST_MINUS;
        ST_MINUS:  state <= ST_DONE;
        ST_DONE:   if (out_fire) state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: sv/n7s_checker.sv
// ----------------------------------------------------------------------------
// n7s_checker
// Port-level checks for the seven-segment coder.
// ----------------------------------------------------------------------------
`default_nettype none
module n7s_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [71:0] m_tdata
);
  // one item in flight: never ready while a result waits
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("ready with result pending");
  // overflow results show E rightmost
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[64]) |-> (m_tdata[63:56] == 8'h79))
    else $error("overflow without E");
  // result never ends in a plain zero
  a_tz: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[63:56] != 8'h3f)) else $error("trailing zero");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result dropped");
endmodule

bind number_to_seven_segment n7s_checker u_chk (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
`default_nettype wire
